>>> src/ede_pkg.sv
// shared codes and result widths for the edit distance engine
// no dependencies

package ede_pkg;

  localparam int REQ_W = 2;
  localparam int CHAR_W = 8;
  localparam int DIST_W = 6;

  localparam logic [REQ_W-1:0] REQ_FIRST   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SECOND  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

endpackage

>>> src/edit_distance_engine.sv
// levenshtein edit distance engine: string stores, row memory and cell sequencer
// depends on ede_pkg

// Items with req_type first or second append char_value to the first or second
// string store (MAX_LEN bytes each); a character sent to a full store is dropped
// and the overflow flag is raised for the next result. Code 3 is taken and
// ignored. A compute item yields one result item (distance, overflow), then
// clears both lengths and the flag. While a compute runs, req_stall is high. When
// either string is empty the sequencer goes straight to the done state. Otherwise
// the single-row memory is seeded with 0..lb, then each of the la rows writes its
// column zero and takes each cell in two states (S_READ: one read of the row
// memory and second string; S_CELL: one compare, min and write-back): the row
// memory's single write port and the shared min-of-three unit set this schedule.
// Distances above 63 saturate at 63. Loads are taken while a result still waits.

module edit_distance_engine #(
  parameter int MAX_LEN = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [ede_pkg::REQ_W-1:0]   req_type,
  input  logic [ede_pkg::CHAR_W-1:0]  char_value,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [ede_pkg::DIST_W-1:0]  distance,
  output logic                        overflow
);

  import ede_pkg::*;

  // lengths and cell values both run 0..MAX_LEN
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CMP_W = (LEN_W > DIST_W) ? LEN_W : DIST_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROW_START,
    S_READ,
    S_CELL,
    S_DONE
  } state_t;

  state_t state;

  // string stores and the single working row
  logic [CHAR_W-1:0] first_mem  [MAX_LEN];
  logic [CHAR_W-1:0] second_mem [MAX_LEN];
  logic [LEN_W-1:0]  row_mem    [MAX_LEN+1];

  logic [LEN_W-1:0]  first_length;
  logic [LEN_W-1:0]  second_length;
  logic              overflow_seen;

  // sequencer counters and the recurrence's neighbours
  logic [LEN_W-1:0]  i_cnt;
  logic [LEN_W-1:0]  j_cnt;
  logic [LEN_W-1:0]  left;   // current row, column j-1
  logic [LEN_W-1:0]  diag;   // previous row, column j-1

  // registered read data
  logic [CHAR_W-1:0] a_q;
  logic [CHAR_W-1:0] b_q;
  logic [LEN_W-1:0]  row_q;

  logic              accept;
  logic              out_free;
  logic              first_full;
  logic              second_full;
  logic [IDX_W-1:0]  a_idx;
  logic [IDX_W-1:0]  b_idx;

  // shared min-of-three unit
  logic [LEN_W:0]    up_cost;
  logic [LEN_W:0]    left_cost;
  logic [LEN_W:0]    diag_cost;
  logic [LEN_W:0]    min_ab;
  logic [LEN_W:0]    min_abc;
  logic [LEN_W-1:0]  cell_value;

  // row memory write port
  logic              row_we;
  logic [LEN_W-1:0]  row_waddr;
  logic [LEN_W-1:0]  row_wdata;

  logic [DIST_W-1:0] dist_sat;

  assign req_stall   = (state != S_IDLE);
  assign accept      = req_valid && !req_stall;
  assign out_free    = !res_valid || !res_stall;
  assign first_full  = (first_length == LEN_W'(MAX_LEN));
  assign second_full = (second_length == LEN_W'(MAX_LEN));
  assign a_idx       = IDX_W'(i_cnt - 1'b1);
  assign b_idx       = IDX_W'(j_cnt - 1'b1);

  always_comb begin
    up_cost   = (LEN_W+1)'(row_q) + 1'b1;
    left_cost = (LEN_W+1)'(left) + 1'b1;
    diag_cost = (LEN_W+1)'(diag) + (LEN_W+1)'(a_q != b_q);
    min_ab    = (up_cost < left_cost) ? up_cost : left_cost;
    min_abc   = (min_ab < diag_cost) ? min_ab : diag_cost;
    cell_value = LEN_W'(min_abc);
  end

  // one write a cycle: seed, column zero of a row, or a finished cell
  always_comb begin
    row_we    = 1'b0;
    row_waddr = j_cnt;
    row_wdata = cell_value;
    unique case (state)
      S_INIT: begin
        row_we    = 1'b1;
        row_wdata = j_cnt;
      end
      S_ROW_START: begin
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = i_cnt;
      end
      S_CELL: begin
        row_we = 1'b1;
      end
      default: begin
        row_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (CMP_W'(left) > CMP_W'(DIST_MAX)) begin
      dist_sat = DIST_MAX;
    end else begin
      dist_sat = DIST_W'(left);
    end
  end

  // memories: registered reads, one write port each
  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_FIRST && !first_full) begin
      first_mem[IDX_W'(first_length)] <= char_value;
    end
    if (accept && req_type == REQ_SECOND && !second_full) begin
      second_mem[IDX_W'(second_length)] <= char_value;
    end
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    a_q   <= first_mem[a_idx];
    b_q   <= second_mem[b_idx];
    row_q <= row_mem[j_cnt];
  end

  // sequencer, lengths and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_length  <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      // the done state drives the flag itself
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (req_type == REQ_FIRST) begin
              if (first_full) begin
                overflow_seen <= 1'b1;
              end else begin
                first_length <= first_length + 1'b1;
              end
            end else if (req_type == REQ_SECOND) begin
              if (second_full) begin
                overflow_seen <= 1'b1;
              end else begin
                second_length <= second_length + 1'b1;
              end
            end else if (req_type == REQ_COMPUTE) begin
              // an empty string gives the other's length at once
              if (first_length == '0 || second_length == '0) begin
                left  <= (first_length == '0) ? second_length : first_length;
                state <= S_DONE;
              end else begin
                j_cnt <= '0;
                state <= S_INIT;
              end
            end else begin
              // unused code: nothing to do
              state <= S_IDLE;
            end
          end
        end
        S_INIT: begin
          if (j_cnt == second_length) begin
            i_cnt <= LEN_W'(1);
            state <= S_ROW_START;
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
        S_ROW_START: begin
          left  <= i_cnt;
          diag  <= i_cnt - 1'b1;
          j_cnt <= LEN_W'(1);
          state <= S_READ;
        end
        S_READ: begin
          state <= S_CELL;
        end
        S_CELL: begin
          left <= cell_value;
          diag <= row_q;
          if (j_cnt == second_length) begin
            if (i_cnt == first_length) begin
              state <= S_DONE;
            end else begin
              i_cnt <= i_cnt + 1'b1;
              state <= S_ROW_START;
            end
          end else begin
            j_cnt <= j_cnt + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid     <= 1'b1;
            distance      <= dist_sat;
            overflow      <= overflow_seen;
            first_length  <= '0;
            second_length <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // cell column stays inside the second string
  a_cell_col: assert property (@(posedge clk) disable iff (rst)
    (state == S_CELL) |-> (j_cnt != '0 && j_cnt <= second_length))
    else $error("cell column out of range");

  // row index stays inside the first string
  a_row_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW_START) |-> (i_cnt != '0 && i_cnt <= first_length))
    else $error("row index out of range");

  // neighbouring cells of the matrix differ by at most one
  a_neighbours: assert property (@(posedge clk) disable iff (rst)
    (state == S_CELL) |->
      ((LEN_W+1)'(left) <= (LEN_W+1)'(diag) + 1'b1 &&
       (LEN_W+1)'(diag) <= (LEN_W+1)'(left) + 1'b1))
    else $error("left and diagonal cells differ by more than one");

  // a compute on two loaded strings starts the seeding sweep
  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_COMPUTE && first_length != '0 && second_length != '0)
      |=> (state == S_INIT && j_cnt == '0))
    else $error("compute did not start seeding");

  // stores never claim more than their capacity
  a_len: assert property (@(posedge clk) disable iff (rst)
    (first_length <= LEN_W'(MAX_LEN) && second_length <= LEN_W'(MAX_LEN)))
    else $error("string length beyond capacity");

endmodule

>>> test/edit_distance_engine_checker.sv
// checker for the edit distance engine: watches both channels, predicts each result
// and compares it field by field; depends on ede_pkg
`timescale 1ns / 100ps

module edit_distance_engine_checker #(
  parameter int MAX_LEN = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic [ede_pkg::REQ_W-1:0]   req_type,
  input  logic [ede_pkg::CHAR_W-1:0]  char_value,
  input  logic                        res_valid,
  input  logic                        res_stall,
  input  logic [ede_pkg::DIST_W-1:0]  distance,
  input  logic                        overflow,
  output int                          fail_count,
  output int                          pending_results,
  output int                          results_checked,
  output int                          overflow_results
);

  import ede_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] edits;
    logic              dropped;
  } edit_result_t;

  edit_result_t       awaited_results[$];
  logic [CHAR_W-1:0]  first_chars [MAX_LEN];
  logic [CHAR_W-1:0]  second_chars [MAX_LEN];
  int                 first_len;
  int                 second_len;
  logic               chars_dropped;
  int                 fails;
  int                 checked;
  int                 flagged;

  // two-row levenshtein over the loaded prefixes, saturated to the result width
  function automatic logic [DIST_W-1:0] levenshtein(int la, int lb);
    int upper_row [MAX_LEN+1];
    int lower_row [MAX_LEN+1];
    int best;
    int cost;
    for (int j = 0; j <= lb; j++) upper_row[j] = j;
    for (int i = 1; i <= la; i++) begin
      lower_row[0] = i;
      for (int j = 1; j <= lb; j++) begin
        cost = (first_chars[i-1] == second_chars[j-1]) ? 0 : 1;
        best = upper_row[j] + 1;
        if (lower_row[j-1] + 1 < best) best = lower_row[j-1] + 1;
        if (upper_row[j-1] + cost < best) best = upper_row[j-1] + cost;
        lower_row[j] = best;
      end
      upper_row = lower_row;
    end
    if (upper_row[lb] > int'(DIST_MAX)) return DIST_MAX;
    return DIST_W'(upper_row[lb]);
  endfunction

  always @(posedge clk) begin
    edit_result_t want;
    if (rst) begin
      awaited_results.delete();
      first_len = 0;
      second_len = 0;
      chars_dropped = 1'b0;
    end else begin
      // results first: one taken this edge always belongs to an earlier compute
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: distance %0d overflow %0b", distance, overflow);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (distance !== want.edits) begin
            $error("distance: expected %0d, got %0d", want.edits, distance);
            fails++;
          end
          if (overflow !== want.dropped) begin
            $error("overflow: expected %0b, got %0b", want.dropped, overflow);
            fails++;
          end
          checked++;
          if (want.dropped) flagged++;
        end
      end
      if (req_valid && !req_stall) begin
        case (req_type)
          REQ_FIRST: begin
            if (first_len < MAX_LEN) begin
              first_chars[first_len] = char_value;
              first_len++;
            end else begin
              chars_dropped = 1'b1;
            end
          end
          REQ_SECOND: begin
            if (second_len < MAX_LEN) begin
              second_chars[second_len] = char_value;
              second_len++;
            end else begin
              chars_dropped = 1'b1;
            end
          end
          REQ_COMPUTE: begin
            want.edits = levenshtein(first_len, second_len);
            want.dropped = chars_dropped;
            awaited_results.insert(awaited_results.size(), want);
            first_len = 0;
            second_len = 0;
            chars_dropped = 1'b0;
          end
          default: ;
        endcase
      end
    end
    pending_results <= awaited_results.size();
    fail_count <= fails;
    results_checked <= checked;
    overflow_results <= flagged;
  end

endmodule

>>> test/edit_distance_engine_tb.sv
// testbench top for the edit distance engine: clock, reset, item stimulus and verdict
// depends on ede_pkg, edit_distance_engine and edit_distance_engine_checker
`timescale 1ns / 100ps

module edit_distance_engine_tb;

  import ede_pkg::*;

  localparam int MAX_LEN = 32;
  localparam int ITEM_TARGET = 750;
  // room for the slowest computes, at full store size, plus receiver stalls
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 60;
  // longest string a job may offer, four past the store size
  localparam int BUF_LEN = MAX_LEN + 4;
  // the one request code the package leaves unnamed: taken and ignored
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_t;
  typedef enum int {ALPHA_NARROW, ALPHA_FULL, ALPHA_SPLIT} alphabet_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [REQ_W-1:0]   req_type = '0;
  logic [CHAR_W-1:0]  char_value = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [DIST_W-1:0]  distance;
  logic               overflow;

  int fail_count;
  int pending_results;
  int results_checked;
  int overflow_results;

  int items_sent = 0;
  int computes_sent = 0;
  int burst_left = 0;
  bit gaps_enabled = 1'b0;
  bit hold_request = 1'b0;

  edit_distance_engine #(
    .MAX_LEN    (MAX_LEN)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .char_value (char_value),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .distance   (distance),
    .overflow   (overflow)
  );

  edit_distance_engine_checker #(
    .MAX_LEN          (MAX_LEN)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req_type         (req_type),
    .char_value       (char_value),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .distance         (distance),
    .overflow         (overflow),
    .fail_count       (fail_count),
    .pending_results  (pending_results),
    .results_checked  (results_checked),
    .overflow_results (overflow_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("edit_distance_engine_tb: done, errors");
    $finish;
  end

  // receiver: stall pattern of its own, switching to a new random mode whenever its stretch runs out;
  // on request it holds off for a long stretch so the engine backs up
  initial begin : receiver
    rx_mode_t     mode;
    int           mode_left;
    logic [7:0]   pattern;
    mode = RX_FREE;
    mode_left = 0;
    pattern = 8'b0010_0110;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        pattern = {pattern[6:0], pattern[7]};
        case (mode)
          RX_FREE:    res_stall <= 1'b0;
          RX_RANDOM:  res_stall <= ($urandom_range(0, 99) < 30);
          RX_PATTERN: res_stall <= pattern[0];
          default:    res_stall <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // offer one item and hold it until taken; bursts of random length with idle
  // gaps between them unless gaps are switched off for a stretch
  task automatic send_item(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] ch);
    int gap;
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    req_valid <= 1'b1;
    req_type <= kind;
    char_value <= ch;
    do @(posedge clk); while (req_stall);
    if (kind != REQ_IGNORED) items_sent++;
    if (kind == REQ_COMPUTE) computes_sent++;
  endtask

  // stop offering and wait for every outstanding result; the first edge lets
  // the checker count a compute taken at the current edge
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // short lengths mostly, sometimes up to a full store, now and then past it
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, MAX_LEN);
    return $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(alphabet_t alpha);
    if (alpha == ALPHA_NARROW) return 8'h61 + CHAR_W'($urandom_range(0, 3));
    return CHAR_W'($urandom);
  endfunction

  // one well-formed job: both strings loaded in random interleaving, stray
  // ignored codes sprinkled in, then a compute; a narrow alphabet or a second
  // string largely copied from the first gives matches and small distances
  task automatic run_job(int la, int lb, alphabet_t alpha, bit similar);
    logic [CHAR_W-1:0] first_buf [BUF_LEN];
    logic [CHAR_W-1:0] second_buf [BUF_LEN];
    int a;
    int b;
    for (int i = 0; i < la; i++)
      first_buf[i] = (alpha == ALPHA_SPLIT) ? 8'h00 : pick_char(alpha);
    for (int j = 0; j < lb; j++) begin
      if (alpha == ALPHA_SPLIT) second_buf[j] = 8'hFF;
      else if (similar && j < la && $urandom_range(0, 9) < 7) second_buf[j] = first_buf[j];
      else second_buf[j] = pick_char(alpha);
    end
    a = 0;
    b = 0;
    while (a < la || b < lb) begin
      if ($urandom_range(0, 19) == 0) send_item(REQ_IGNORED, CHAR_W'($urandom));
      if (b >= lb || (a < la && $urandom_range(0, 1) == 1)) begin
        send_item(REQ_FIRST, first_buf[a]);
        a++;
      end else begin
        send_item(REQ_SECOND, second_buf[b]);
        b++;
      end
    end
    send_item(REQ_COMPUTE, CHAR_W'($urandom));
  endtask

  initial begin : stimulus
    int job_count;
    alphabet_t alpha;
    job_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty strings, one side empty, single substitution, equal
    // strings, ignored codes with extreme characters, ignored code mid-load
    send_item(REQ_COMPUTE, 8'h00);
    send_item(REQ_FIRST, 8'h00);
    send_item(REQ_COMPUTE, 8'hFF);
    send_item(REQ_SECOND, 8'hFF);
    send_item(REQ_COMPUTE, 8'h00);
    send_item(REQ_FIRST, 8'h00);
    send_item(REQ_SECOND, 8'hFF);
    send_item(REQ_COMPUTE, 8'h00);
    send_item(REQ_FIRST, 8'hAA);
    send_item(REQ_FIRST, 8'h55);
    send_item(REQ_SECOND, 8'hAA);
    send_item(REQ_SECOND, 8'h55);
    send_item(REQ_COMPUTE, 8'hFF);
    send_item(REQ_IGNORED, 8'hFF);
    send_item(REQ_IGNORED, 8'h00);
    send_item(REQ_COMPUTE, 8'h00);
    send_item(REQ_FIRST, 8'h01);
    send_item(REQ_IGNORED, 8'h02);
    send_item(REQ_SECOND, 8'h01);
    send_item(REQ_COMPUTE, 8'h00);
    wait_drained();

    // both stores overfilled with disjoint bytes: largest distance, flag raised
    gaps_enabled = 1'b1;
    run_job(MAX_LEN + 2, MAX_LEN + 1, ALPHA_SPLIT, 1'b0);
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      job_count++;
      // long receiver hold while the sender keeps going flat out, so the
      // pending result blocks the next compute and the input stalls
      if (job_count == 12) hold_request = 1'b1;
      if (job_count >= 12 && job_count < 16) gaps_enabled = 1'b0;
      else gaps_enabled = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 6) == 0) begin
        // noise: arbitrary codes, a compute may land on half-loaded strings
        repeat ($urandom_range(1, 6))
          send_item(REQ_W'($urandom_range(0, 3)), CHAR_W'($urandom));
      end else begin
        alpha = ($urandom_range(0, 19) == 0) ? ALPHA_SPLIT :
                alphabet_t'($urandom_range(0, 1));
        run_job(pick_len(), pick_len(), alpha, $urandom_range(0, 1));
      end
      if (job_count % 15 == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d load and compute items, %0d computes", items_sent, computes_sent);
    $display("%0d results checked, %0d of them with the overflow flag",
             results_checked, overflow_results);
    if (fail_count == 0) begin
      $display("edit_distance_engine_tb: done, clean");
    end else begin
      $display("edit_distance_engine_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/ede_pkg.sv
src/edit_distance_engine.sv
test/edit_distance_engine_checker.sv
test/edit_distance_engine_tb.sv
